>>> src/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg
// Shared types and constants for the sync byte frame receiver.
// ----------------------------------------------------------------------------
package sbfr_pkg;

    // One bus byte.
    typedef logic [7:0] byte_t;

    // Frame position: zero while hunting, 1..7 counts received frame bytes.
    typedef logic [2:0] pos_t;

    // Byte that always opens a new frame.
    localparam byte_t SYNC_BYTE = 8'h1C;

    // Number of payload bytes held between the start byte and the checksum.
    localparam int PAYLOAD_LEN = 6;

    // Position codes.
    localparam pos_t POS_HUNT  = 3'd0;
    localparam pos_t POS_FIRST = 3'd1;
    localparam pos_t POS_CHECK = 3'd7;

    // Control from the frame sequencer to the byte cells and output stage.
    typedef struct packed {
        logic shift;  // a payload byte enters the cell row
        logic emit;   // the checksum byte matched: load the result
    } sbfr_ctrl_t;

endpackage

>>> src/sbfr_cell.sv
// ----------------------------------------------------------------------------
// sbfr_cell
// One byte cell of the payload row; takes its neighbor's byte on a shift.
// ----------------------------------------------------------------------------
module sbfr_cell
    import sbfr_pkg::*;
(
    input  logic  aclk,
    input  logic  shift,
    input  byte_t d_in,
    output byte_t q
);

    byte_t data_reg;
    byte_t data_next;

    // Hold the byte unless the row moves forward.
    always_comb begin
        data_next = shift ? d_in : data_reg;
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

>>> src/sbfr_ctrl.sv
// ----------------------------------------------------------------------------
// sbfr_ctrl
// Frame sequencer: tracks the frame position and the running byte sum and
// decides when the payload row shifts and when a good frame is delivered.
// ----------------------------------------------------------------------------
module sbfr_ctrl
    import sbfr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       xfer,
    input  byte_t      rx_byte,
    output sbfr_ctrl_t ctl
);

    pos_t  pos_reg;
    pos_t  pos_next;
    byte_t sum_reg;
    byte_t sum_next;
    byte_t sum_total;

    // Sum of the frame so far plus this byte; zero means the checksum matches.
    assign sum_total = sum_reg + rx_byte;

    // Next position and sum, and the controls for this transfer.
    always_comb begin
        pos_next  = pos_reg;
        sum_next  = sum_reg;
        ctl.shift = 1'b0;
        ctl.emit  = 1'b0;
        if (xfer) begin
            if (rx_byte == SYNC_BYTE) begin
                pos_next = POS_FIRST;
                sum_next = SYNC_BYTE;
            end else if (pos_reg == POS_HUNT) begin
                pos_next = POS_HUNT;
            end else if (pos_reg != POS_CHECK) begin
                ctl.shift = 1'b1;
                sum_next  = sum_total;
                pos_next  = pos_reg + 3'd1;
            end else begin
                ctl.emit = (sum_total == 8'h00);
                pos_next = POS_HUNT;
                sum_next = 8'h00;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_HUNT;
            sum_reg <= 8'h00;
        end else begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

endmodule

>>> src/sync_byte_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_byte_frame_receiver
// Deframer for fixed eight-byte bus frames with a sum checksum.
// ----------------------------------------------------------------------------
// The block takes one bus byte per transfer and accepts a new byte every
// cycle; it stalls only while a delivered frame waits in the output register
// and m_ready is low. Byte 0x1C always starts a frame, even in mid-frame or in
// the checksum slot; bytes outside a frame are dropped. The six payload bytes
// move through a row of byte cells, and a running sum checks the last byte
// against the two's complement of the sum of the first seven. A good frame
// appears on the m_ side in the cycle after its checksum byte is transferred;
// a bad frame produces nothing.
module sync_byte_frame_receiver
    import sbfr_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  byte_t s_rx_byte,
    output logic  m_valid,
    input  logic  m_ready,
    output byte_t m_area_byte,
    output byte_t m_frame_byte2,
    output byte_t m_frame_byte3,
    output byte_t m_frame_byte4,
    output byte_t m_frame_byte5,
    output byte_t m_join_byte,
    output byte_t m_check_byte
);

    logic       s_xfer;
    sbfr_ctrl_t ctl;
    byte_t      cell_q [PAYLOAD_LEN];
    byte_t      cell_d [PAYLOAD_LEN];

    logic  m_valid_reg;
    logic  m_valid_next;
    byte_t out_reg [PAYLOAD_LEN];
    byte_t check_reg;

    // The output register frees up in the same cycle its result is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    sbfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .xfer    (s_xfer),
        .rx_byte (s_rx_byte),
        .ctl     (ctl)
    );

    // Payload row: new bytes enter at the far end and move toward cell 0.
    for (genvar i = 0; i < PAYLOAD_LEN; i++) begin : g_cell
        if (i == PAYLOAD_LEN - 1) begin : g_tail
            assign cell_d[i] = s_rx_byte;
        end else begin : g_link
            assign cell_d[i] = cell_q[i + 1];
        end
        sbfr_cell u_cell (
            .aclk  (aclk),
            .shift (ctl.shift),
            .d_in  (cell_d[i]),
            .q     (cell_q[i])
        );
    end

    // Output valid: set by a good frame, cleared once the result is taken.
    always_comb begin
        if (ctl.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is captured from the cell row on a good frame.
    always_ff @(posedge aclk) begin
        if (ctl.emit) begin
            out_reg   <= cell_q;
            check_reg <= s_rx_byte;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_area_byte   = out_reg[0];
    assign m_frame_byte2 = out_reg[1];
    assign m_frame_byte3 = out_reg[2];
    assign m_frame_byte4 = out_reg[3];
    assign m_frame_byte5 = out_reg[4];
    assign m_join_byte   = out_reg[5];
    assign m_check_byte  = check_reg;

`ifndef SYNTHESIS
    // A result only appears after an input transfer.
    a_valid_from_input: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready))
        else $error("result appeared without an input transfer");

    // A start byte never completes a frame.
    a_sync_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_rx_byte == SYNC_BYTE) |=> !$rose(m_valid))
        else $error("start byte produced a result");

    // No input is taken while a result is stalled.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output stalled");

    // The row never shifts on the transfer that delivers a frame, and a frame is delivered only on a transfer.
    a_emit_no_shift: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.emit |-> (!ctl.shift && s_xfer))
        else $error("emit with shift or without transfer");
`endif

endmodule

>>> tb/sv/sync_byte_frame_receiver_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_byte_frame_receiver_tb
// Self-checking bench for the eight-byte frame receiver. A stimulus queue
// holds bus bytes: a short directed run over idle bytes, restarts and
// checksum cases, then random frames, damaged frames and line noise. A
// clocked driver sends the bytes with random gaps. Each accepted byte goes
// through a frame tracker in the bench that predicts the delivered frames.
// A clocked monitor applies random back-pressure and checks every delivered
// frame field by field.
// ----------------------------------------------------------------------------
module sync_byte_frame_receiver_tb;
    import sbfr_pkg::*;

    localparam int ITEM_TARGET    = 1050;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    // Frame bytes 1..7, index k holds frame byte k+1.
    typedef logic [PAYLOAD_LEN:0][7:0] frame_t;

    typedef enum {FRAME_GOOD, FRAME_BAD_SUM, FRAME_CUT} frame_kind_t;

    logic  aclk;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    byte_t s_rx_byte = 8'h00;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    byte_t m_area_byte;
    byte_t m_frame_byte2;
    byte_t m_frame_byte3;
    byte_t m_frame_byte4;
    byte_t m_frame_byte5;
    byte_t m_join_byte;
    byte_t m_check_byte;

    sync_byte_frame_receiver dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_rx_byte     (s_rx_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_area_byte   (m_area_byte),
        .m_frame_byte2 (m_frame_byte2),
        .m_frame_byte3 (m_frame_byte3),
        .m_frame_byte4 (m_frame_byte4),
        .m_frame_byte5 (m_frame_byte5),
        .m_join_byte   (m_join_byte),
        .m_check_byte  (m_check_byte)
    );

    // Bytes still to send and frames still to arrive.
    byte_t  bus_bytes [$];
    frame_t expected_frames [$];

    // Frame tracker state in the bench.
    logic [3:0] frame_pos = 4'd0;
    byte_t      frame_sum = 8'h00;
    byte_t      payload_store [PAYLOAD_LEN];

    int     errors      = 0;
    int     calm_left   = 0;
    int     send_gap    = 0;
    int     stall_left  = 0;
    int     idle_cycles = 0;
    frame_t got_frame;
    frame_t want_frame;
    string  field_label [PAYLOAD_LEN + 1] = '{"area_byte", "frame_byte2", "frame_byte3",
        "frame_byte4", "frame_byte5", "join_byte", "check_byte"};

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Gap length: mostly none or short, now and then long, with calm stretches.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        if (r < 2) begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Payload byte with extra weight on the extremes; never the start byte.
    function automatic byte_t pick_payload_byte();
        int    r;
        byte_t b;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'h00;
        if (r < 20) return 8'hFF;
        do b = byte_t'($urandom_range(0, 255)); while (b == SYNC_BYTE);
        return b;
    endfunction

    // Queue a frame: start byte, payload, and a good or damaged checksum.
    // A cut frame stops after cut_len payload bytes with no checksum.
    task automatic push_frame(input byte_t pl [PAYLOAD_LEN], input frame_kind_t kind,
                              input int cut_len);
        byte_t sum;
        int    n;
        sum = SYNC_BYTE;
        n = (kind == FRAME_CUT) ? cut_len : PAYLOAD_LEN;
        bus_bytes.push_back(SYNC_BYTE);
        for (int k = 0; k < n; k++) begin
            bus_bytes.push_back(pl[k]);
            sum = sum + pl[k];
        end
        if (kind == FRAME_GOOD) begin
            bus_bytes.push_back(8'h00 - sum);
        end else if (kind == FRAME_BAD_SUM) begin
            bus_bytes.push_back((8'h00 - sum) ^ byte_t'($urandom_range(1, 255)));
        end
    endtask

    // Frame tracker: follows one accepted byte and queues any frame it completes.
    task automatic absorb_byte(input byte_t b);
        frame_t f;
        if (b == SYNC_BYTE) begin
            frame_pos = 4'd1;
            frame_sum = SYNC_BYTE;
        end else if (frame_pos != 4'd0) begin
            if (frame_pos <= PAYLOAD_LEN) begin
                payload_store[frame_pos - 1] = b;
                frame_sum = frame_sum + b;
                frame_pos = frame_pos + 4'd1;
            end else begin
                // Checksum slot: deliver only when the byte completes a zero sum.
                if (b == byte_t'(8'h00 - frame_sum)) begin
                    for (int k = 0; k < PAYLOAD_LEN; k++) f[k] = payload_store[k];
                    f[PAYLOAD_LEN] = b;
                    expected_frames.push_back(f);
                end
                frame_pos = 4'd0;
                frame_sum = 8'h00;
            end
        end
    endtask

    // Driver: presents queued bytes and tracks each completed transfer.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_rx_byte <= 8'h00;
        end else begin
            if (s_valid && s_ready) absorb_byte(s_rx_byte);
            if (s_valid && !s_ready) begin
                // Hold the byte until it is taken.
            end else if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (bus_bytes.size() > 0) begin
                s_valid   <= 1'b1;
                s_rx_byte <= bus_bytes.pop_front();
                send_gap = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each delivered frame and applies back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got_frame = {m_check_byte, m_join_byte, m_frame_byte5, m_frame_byte4,
                             m_frame_byte3, m_frame_byte2, m_area_byte};
                if (expected_frames.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, actual %h",
                             $time, got_frame);
                    errors++;
                end else begin
                    want_frame = expected_frames.pop_front();
                    for (int k = 0; k <= PAYLOAD_LEN; k++) begin
                        if (got_frame[k] !== want_frame[k]) begin
                            $display("%0t: %s mismatch, expected %h, actual %h",
                                     $time, field_label[k], want_frame[k], got_frame[k]);
                            errors++;
                        end
                    end
                end
                stall_left = pick_gap();
            end else if ($urandom_range(0, 49) == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transfer on either side ends the run.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : stimulus
        byte_t pl [PAYLOAD_LEN];
        int    noise_bytes;
        int    r;
        int    n;
        noise_bytes = 0;

        // An idle byte before any start, then a start byte cut short by another.
        bus_bytes.push_back(8'hFF);
        bus_bytes.push_back(SYNC_BYTE);
        bus_bytes.push_back(8'h00);
        // Full frame with a damaged checksum.
        pl = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
        push_frame(pl, FRAME_BAD_SUM, 0);
        // Start byte in the checksum slot opens the next frame, which is good.
        pl = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20};
        push_frame(pl, FRAME_CUT, PAYLOAD_LEN);
        pl = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00};
        push_frame(pl, FRAME_GOOD, 0);

        // Random part: mostly good frames, some damaged or cut, some noise.
        while (bus_bytes.size() - noise_bytes < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            for (int k = 0; k < PAYLOAD_LEN; k++) pl[k] = pick_payload_byte();
            if (r < 65) begin
                push_frame(pl, FRAME_GOOD, 0);
            end else if (r < 75) begin
                push_frame(pl, FRAME_BAD_SUM, 0);
            end else if (r < 85) begin
                push_frame(pl, FRAME_CUT, $urandom_range(0, PAYLOAD_LEN));
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++) bus_bytes.push_back(byte_t'($urandom_range(0, 255)));
                noise_bytes += n;
            end
        end

        aresetn = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all bytes sent and every predicted frame delivered.
        while (bus_bytes.size() > 0 || s_valid || expected_frames.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
